@@ sv/wdadj_pkg.sv @@
// wdadj_pkg: types, codes, the arctangent table and small helpers for the
// wind direction / adjoint pipeline. No dependencies.
package wdadj_pkg;

	localparam logic [1:0] KIND_DIR = 2'd0;
	localparam logic [1:0] KIND_TL  = 2'd1;
	localparam logic [1:0] KIND_ADJ = 2'd2;

	localparam int unsigned CORDIC_STEPS = 24;
	localparam int unsigned QBITS        = 33;   // quotient bits before the cap
	localparam int unsigned NW           = 71;   // numerator width
	localparam logic [17:0] FULL_TURN    = 18'd23040;
	localparam logic [17:0] DIR_MAX      = 18'd23039;
	localparam logic [33:0] QUARTER_TURN = 34'd1686629713;
	localparam logic [22:0] DPR_RESET    = 23'd3754936;

	// atan(2^-i) in units of 2^-30 rad
	localparam logic [31:0] ATAN_TAB [0:23] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	typedef struct packed {
		logic [1:0]         kind;
		logic               calm;
		logic signed [31:0] ea;
		logic signed [31:0] na;
	} ctl_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic signed [57:0] zk;
		logic [14:0]        dir;
	} cdc_t;

	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [39:0] d;
		logic [39:0] rem;
		logic [32:0] nb;
		logic [32:0] q;
	} lane_t;

	function automatic logic [15:0] abs16(logic signed [15:0] a);
		return a[15] ? 16'(-a) : 16'(a);
	endfunction

	function automatic logic [31:0] abs32(logic signed [31:0] a);
		return a[31] ? 32'(-a) : 32'(a);
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [35:0] a);
		logic signed [31:0] r;
		if (a > 36'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (a < -36'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = a[31:0];
		end
		return r;
	endfunction

	// one vectoring step, shift i
	function automatic cdc_t cdc_step(cdc_t c, int unsigned i);
		cdc_t r;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] ang;
		r   = c;
		dx  = c.y >>> i;
		dy  = c.x >>> i;
		ang = $signed({2'b00, ATAN_TAB[i[4:0]]});
		if (!c.y[33]) begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + ang;
		end else begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - ang;
		end
		return r;
	endfunction

	// one restoring division step
	function automatic lane_t div_step(lane_t l);
		lane_t r;
		logic [40:0] t;
		r = l;
		t = {l.rem, l.nb[32]};
		if (t >= {1'b0, l.d}) begin
			r.rem = 40'(t - {1'b0, l.d});
			r.q   = {l.q[31:0], 1'b1};
		end else begin
			r.rem = t[39:0];
			r.q   = {l.q[31:0], 1'b0};
		end
		r.nb = {l.nb[31:0], 1'b0};
		return r;
	endfunction

endpackage

@@ sv/wind_direction_with_adjoint.sv @@
// wind_direction_with_adjoint: pipelined wind direction (CORDIC), its
// tangent-linear increment and adjoint accumulation. Depends on wdadj_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | start / busy           | kind, winds, perturbations, adjoints
//  result   | done (one-cycle strobe)| direction, direction_increment, *_adjoint_out
//  config   | cfg_valid / cfg_ready  | cfg_data (degrees_per_radian, Q7.16)
//
// One item per clock; busy is never raised. The pipe has five front
// stages (capture, products, lane select, scale multiply, rounding add), the
// loaded divider, its 33 restoring steps and the output register. The 24
// CORDIC steps and the angle scaling run alongside the divider. Reset clears
// the valid bits and loads the default scale. The receiver cannot stall, so
// the pipe never holds.
module wind_direction_with_adjoint (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic signed [15:0] east_wind,
	input  logic signed [15:0] north_wind,
	input  logic signed [15:0] east_perturbation,
	input  logic signed [15:0] north_perturbation,
	input  logic signed [31:0] east_adjoint_in,
	input  logic signed [31:0] north_adjoint_in,
	input  logic signed [31:0] direction_adjoint,
	output logic               done,
	output logic [14:0]        direction,
	output logic signed [31:0] direction_increment,
	output logic signed [31:0] east_adjoint_out,
	output logic signed [31:0] north_adjoint_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [22:0]        cfg_data
);

	localparam int unsigned NIT = wdadj_pkg::QBITS;

	logic [22:0] k_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= wdadj_pkg::DPR_RESET;
		end else if (cfg_valid) begin
			k_q <= cfg_data;
		end
	end

	// ---- s1: input capture
	logic               v_s1;
	logic [1:0]         kind_s1;
	logic signed [15:0] u_s1, w_s1, du_s1, dw_s1;
	logic signed [31:0] ea_s1, na_s1, da_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		u_s1    <= east_wind;
		w_s1    <= north_wind;
		du_s1   <= east_perturbation;
		dw_s1   <= north_perturbation;
		ea_s1   <= east_adjoint_in;
		na_s1   <= north_adjoint_in;
		da_s1   <= direction_adjoint;
	end

	// ---- s2: products
	logic               v_s2;
	logic [1:0]         kind_s2;
	logic signed [15:0] u_s2, w_s2;
	logic signed [31:0] ea_s2, na_s2;
	logic signed [31:0] uu_s2, ww_s2, wdu_s2, udw_s2;
	logic [47:0]        mwa_s2, mua_s2;
	logic               nege_s2, negn_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		u_s2    <= u_s1;
		w_s2    <= w_s1;
		ea_s2   <= ea_s1;
		na_s2   <= na_s1;
		uu_s2   <= u_s1 * u_s1;
		ww_s2   <= w_s1 * w_s1;
		wdu_s2  <= w_s1 * du_s1;
		udw_s2  <= u_s1 * dw_s1;
		mwa_s2  <= 48'(wdadj_pkg::abs16(w_s1)) * 48'(wdadj_pkg::abs32(da_s1));
		mua_s2  <= 48'(wdadj_pkg::abs16(u_s1)) * 48'(wdadj_pkg::abs32(da_s1));
		nege_s2 <= w_s1[15] != da_s1[31];
		negn_s2 <= (u_s1 != 16'sd0) && ((!u_s1[15]) != da_s1[31]);
	end

	// ---- s3: speed squared, numerator, lane select, quarter-turn
	logic                v_s3;
	wdadj_pkg::ctl_t     ctl_s3;
	wdadj_pkg::cdc_t     cdc_s3;
	logic                nege_s3, negn_s3;
	logic [39:0]         de_s3, dn_s3;
	logic [47:0]         mage_s3, magn_s3;

	logic [31:0]         s_c;
	logic signed [32:0]  n_c;
	logic [31:0]         nabs_c;
	wdadj_pkg::cdc_t     cdc_c;

	always_comb begin
		s_c    = uu_s2 + ww_s2;
		n_c    = 33'(wdu_s2) - 33'(udw_s2);
		nabs_c = n_c[32] ? 32'(-n_c) : n_c[31:0];
		cdc_c    = '0;
		cdc_c.x  = {{4{w_s2[15]}}, w_s2, 14'b0};
		cdc_c.y  = {{4{u_s2[15]}}, u_s2, 14'b0};
		if (w_s2[15]) begin
			// negative north wind: turn a quarter so CORDIC starts in the right half plane
			if (!u_s2[15]) begin
				cdc_c.x = {{4{u_s2[15]}}, u_s2, 14'b0};
				cdc_c.y = -{{4{w_s2[15]}}, w_s2, 14'b0};
				cdc_c.z = $signed(wdadj_pkg::QUARTER_TURN);
			end else begin
				cdc_c.x = -{{4{u_s2[15]}}, u_s2, 14'b0};
				cdc_c.y = {{4{w_s2[15]}}, w_s2, 14'b0};
				cdc_c.z = -$signed(wdadj_pkg::QUARTER_TURN);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3.kind <= kind_s2;
		ctl_s3.calm <= (s_c == 32'd0);
		ctl_s3.ea   <= ea_s2;
		ctl_s3.na   <= na_s2;
		cdc_s3      <= cdc_c;
		if (kind_s2 == wdadj_pkg::KIND_TL) begin
			nege_s3 <= n_c[32];
			de_s3   <= {8'd0, s_c};
			mage_s3 <= {16'd0, nabs_c};
		end else begin
			nege_s3 <= nege_s2;
			de_s3   <= {s_c, 8'd0};
			mage_s3 <= mwa_s2;
		end
		negn_s3 <= negn_s2;
		dn_s3   <= {s_c, 8'd0};
		magn_s3 <= mua_s2;
	end

	// ---- s4: partial products of mag * scale
	logic            v_s4;
	wdadj_pkg::ctl_t ctl_s4;
	wdadj_pkg::cdc_t cdc_s4;
	logic            nege_s4, negn_s4;
	logic [39:0]     de_s4, dn_s4;
	logic [46:0]     ple_s4, phe_s4, pln_s4, phn_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s4  <= ctl_s3;
		cdc_s4  <= cdc_s3;
		nege_s4 <= nege_s3;
		negn_s4 <= negn_s3;
		de_s4   <= de_s3;
		dn_s4   <= dn_s3;
		ple_s4  <= 47'(mage_s3[23:0]) * 47'(k_q);
		phe_s4  <= 47'(mage_s3[47:24]) * 47'(k_q);
		pln_s4  <= 47'(magn_s3[23:0]) * 47'(k_q);
		phn_s4  <= 47'(magn_s3[47:24]) * 47'(k_q);
	end

	// ---- s5: numerator = mag*k + d/2, so the quotient is the rounded result
	logic                     v_s5;
	wdadj_pkg::ctl_t          ctl_s5;
	wdadj_pkg::cdc_t          cdc_s5;
	logic                     nege_s5, negn_s5;
	logic [39:0]              de_s5, dn_s5;
	logic [wdadj_pkg::NW-1:0] ne_s5, nn_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s5  <= ctl_s4;
		cdc_s5  <= cdc_s4;
		nege_s5 <= nege_s4;
		negn_s5 <= negn_s4;
		de_s5   <= de_s4;
		dn_s5   <= dn_s4;
		ne_s5   <= {phe_s4, 24'd0} + 71'(ple_s4) + 71'(de_s4 >> 1);
		nn_s5   <= {phn_s4, 24'd0} + 71'(pln_s4) + 71'(dn_s4 >> 1);
	end

	// ---- iteration stages: index 0 is the loaded divider, j+1 after step j
	logic            v_it   [0:NIT];
	wdadj_pkg::ctl_t ctl_it [0:NIT];
	wdadj_pkg::cdc_t cdc_it [0:NIT];
	wdadj_pkg::lane_t le_it [0:NIT];
	wdadj_pkg::lane_t ln_it [0:NIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_it[0] <= 1'b0;
		end else begin
			v_it[0] <= v_s5;
		end
	end

	// quotient at or above 2^33 saturates the increment and adjoint outputs, so it is just flagged
	always_ff @(posedge clk) begin
		ctl_it[0]     <= ctl_s5;
		cdc_it[0]     <= cdc_s5;
		le_it[0].neg  <= nege_s5;
		le_it[0].ovf  <= {2'b00, ne_s5[70:33]} >= de_s5;
		le_it[0].d    <= de_s5;
		le_it[0].rem  <= {2'b00, ne_s5[70:33]};
		le_it[0].nb   <= ne_s5[32:0];
		le_it[0].q    <= '0;
		ln_it[0].neg  <= negn_s5;
		ln_it[0].ovf  <= {2'b00, nn_s5[70:33]} >= dn_s5;
		ln_it[0].d    <= dn_s5;
		ln_it[0].rem  <= {2'b00, nn_s5[70:33]};
		ln_it[0].nb   <= nn_s5[32:0];
		ln_it[0].q    <= '0;
	end

	for (genvar j = 0; j < NIT; j++) begin : g_it
		wdadj_pkg::cdc_t    cnext;
		logic signed [57:0] rnd;
		logic signed [17:0] rr;

		always_comb begin
			cnext = cdc_it[j];
			rnd   = '0;
			rr    = '0;
			if (j < wdadj_pkg::CORDIC_STEPS) begin
				cnext = wdadj_pkg::cdc_step(cdc_it[j], j);
			end else if (j == wdadj_pkg::CORDIC_STEPS) begin
				cnext.zk = cdc_it[j].z * $signed({1'b0, k_q});
			end else if (j == wdadj_pkg::CORDIC_STEPS + 1) begin
				// round to 1/64 degree, then wrap negative angles
				rnd = cdc_it[j].zk + 58'sh80_0000_0000;
				rr  = rnd[57:40];
				if (rr[17]) begin
					rr = rr + $signed(wdadj_pkg::FULL_TURN);
				end
				if (rr[17]) begin
					rr = '0;
				end else if (rr > $signed(wdadj_pkg::DIR_MAX)) begin
					rr = $signed(wdadj_pkg::DIR_MAX);
				end
				cnext.dir = rr[14:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_it[j+1] <= 1'b0;
			end else begin
				v_it[j+1] <= v_it[j];
			end
		end

		always_ff @(posedge clk) begin
			ctl_it[j+1] <= ctl_it[j];
			cdc_it[j+1] <= cnext;
			le_it[j+1]  <= wdadj_pkg::div_step(le_it[j]);
			ln_it[j+1]  <= wdadj_pkg::div_step(ln_it[j]);
		end
	end

	// ---- output: sign, accumulate, saturate, select by kind
	wdadj_pkg::ctl_t    cf;
	logic [33:0]        te_c, tn_c;
	logic signed [35:0] se_c, sn_c;
	logic               done_q;
	logic [14:0]        dir_q;
	logic signed [31:0] inc_q, eo_q, no_q;

	always_comb begin
		cf   = ctl_it[NIT];
		te_c = le_it[NIT].ovf ? 34'h2_0000_0000 : {1'b0, le_it[NIT].q};
		tn_c = ln_it[NIT].ovf ? 34'h2_0000_0000 : {1'b0, ln_it[NIT].q};
		se_c = $signed({2'b00, te_c});
		sn_c = $signed({2'b00, tn_c});
		if (le_it[NIT].neg) begin
			se_c = -se_c;
		end
		if (ln_it[NIT].neg) begin
			sn_c = -sn_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_it[NIT];
		end
	end

	always_ff @(posedge clk) begin
		dir_q <= '0;
		inc_q <= '0;
		eo_q  <= '0;
		no_q  <= '0;
		case (cf.kind)
			wdadj_pkg::KIND_DIR: begin
				dir_q <= cf.calm ? 15'd0 : cdc_it[NIT].dir;
			end
			wdadj_pkg::KIND_TL: begin
				inc_q <= cf.calm ? 32'sd0 : wdadj_pkg::sat32(se_c);
			end
			wdadj_pkg::KIND_ADJ: begin
				eo_q <= cf.calm ? cf.ea : wdadj_pkg::sat32(36'(cf.ea) + se_c);
				no_q <= cf.calm ? cf.na : wdadj_pkg::sat32(36'(cf.na) + sn_c);
			end
			default: begin
				dir_q <= '0;
			end
		endcase
	end

	assign done                = done_q;
	assign direction           = dir_q;
	assign direction_increment = inc_q;
	assign east_adjoint_out    = eo_q;
	assign north_adjoint_out   = no_q;

endmodule

@@ dv/wind_direction_with_adjoint_tb.sv @@
// wind_direction_with_adjoint_tb: self-checking bench for the wind direction,
// tangent-linear increment and adjoint pipeline. Depends on wdadj_pkg and the RTL.
module wind_direction_with_adjoint_tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         IDLE_LIMIT  = 2000;  // cycles with nothing accepted
	localparam int         DRAIN_WAIT  = 60;    // quiet time that lets the pipe drain

	// one pending entry: either a scale write or a grid point
	typedef struct {
		bit                 is_cfg;
		logic [22:0]        scale;
		logic [1:0]         kind;
		logic signed [15:0] u;
		logic signed [15:0] v;
		logic signed [15:0] du;
		logic signed [15:0] dv;
		logic signed [31:0] ea;
		logic signed [31:0] na;
		logic signed [31:0] da;
	} wind_item_t;

	typedef struct {
		logic [14:0]        dir;
		logic signed [31:0] inc;
		logic signed [31:0] eo;
		logic signed [31:0] no;
	} wind_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         kind = '0;
	logic signed [15:0] east_wind = '0;
	logic signed [15:0] north_wind = '0;
	logic signed [15:0] east_perturbation = '0;
	logic signed [15:0] north_perturbation = '0;
	logic signed [31:0] east_adjoint_in = '0;
	logic signed [31:0] north_adjoint_in = '0;
	logic signed [31:0] direction_adjoint = '0;
	logic               done;
	logic [14:0]        direction;
	logic signed [31:0] direction_increment;
	logic signed [31:0] east_adjoint_out;
	logic signed [31:0] north_adjoint_out;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [22:0]        cfg_data = '0;

	wind_item_t pending_points[$];
	wind_res_t  expected_winds[$];
	logic [22:0] scale_copy = wdadj_pkg::DPR_RESET;  // bench copy of degrees_per_radian
	int errors = 0;
	int idle_cycles = 0;
	int quiet_cycles = 0;
	int gap = 0;
	int kind_count[4] = '{0, 0, 0, 0};
	int scale_writes = 0;
	bit point_taken = 0;
	bit scale_taken = 0;

	always #5 clk = ~clk;

	wind_direction_with_adjoint i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.east_wind(east_wind), .north_wind(north_wind),
		.east_perturbation(east_perturbation), .north_perturbation(north_perturbation),
		.east_adjoint_in(east_adjoint_in), .north_adjoint_in(north_adjoint_in),
		.direction_adjoint(direction_adjoint), .done(done), .direction(direction),
		.direction_increment(direction_increment), .east_adjoint_out(east_adjoint_out),
		.north_adjoint_out(north_adjoint_out), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	function automatic longint unsigned magnitude(longint a);
		return a < 0 ? longint'(-a) : a;
	endfunction

	function automatic longint clamp32(longint a);
		if (a > 64'sd2147483647) return 64'sd2147483647;
		if (a < -64'sd2147483648) return -64'sd2147483648;
		return a;
	endfunction

	// round(mag*k/d), halves away from zero, capped at 2^34
	function automatic longint unsigned round_ratio(longint unsigned mag,
			longint unsigned k, longint unsigned d);
		longint unsigned hi, lo, t;
		hi = mag / d;
		lo = mag % d;
		if (hi >= (64'd1 << 39)) return 64'd1 << 34;
		t = hi * k + (lo * k + d / 2) / d;
		return t > (64'd1 << 34) ? (64'd1 << 34) : t;
	endfunction

	// CORDIC vectoring of (v,u); result in 1/64 degree, wrapped and clamped
	function automatic logic [14:0] wind_bearing(longint u, longint v, logic [22:0] k);
		longint x, y, z, dx, dy, tmp, r;
		if (u == 0 && v == 0) return '0;
		x = v * 16384;
		y = u * 16384;
		z = 0;
		if (x < 0) begin
			tmp = x;
			if (y >= 0) begin
				x = y; y = -tmp; z = longint'(wdadj_pkg::QUARTER_TURN);
			end else begin
				x = -y; y = tmp; z = -longint'(wdadj_pkg::QUARTER_TURN);
			end
		end
		for (int i = 0; i < wdadj_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(wdadj_pkg::ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(wdadj_pkg::ATAN_TAB[i]);
			end
		end
		r = (z * longint'({41'd0, k}) + (64'sd1 <<< 39)) >>> 40;
		if (r < 0) r += 23040;
		if (r < 0) r = 0;
		if (r > 23039) r = 23039;
		return r[14:0];
	endfunction

	function automatic wind_res_t predict_wind(wind_item_t it, logic [22:0] k);
		wind_res_t o;
		longint u, v, du, dv, ea, na, da, s, n, t, te, tn;
		longint unsigned kk, d, am;
		bit ne, nn;
		o = '{default: '0};
		u = it.u; v = it.v; du = it.du; dv = it.dv;
		ea = it.ea; na = it.na; da = it.da;
		s = u * u + v * v;
		kk = {41'd0, k};
		case (it.kind)
			wdadj_pkg::KIND_DIR: o.dir = wind_bearing(u, v, k);
			wdadj_pkg::KIND_TL: begin
				if (s > 0) begin
					n = v * du - u * dv;
					t = round_ratio(magnitude(n), kk, s);
					o.inc = 32'(clamp32(n < 0 ? -t : t));
				end
			end
			wdadj_pkg::KIND_ADJ: begin
				o.eo = it.ea;
				o.no = it.na;
				if (s > 0) begin
					d = s * 256;
					am = magnitude(da);
					te = round_ratio(magnitude(v) * am, kk, d);
					tn = round_ratio(magnitude(u) * am, kk, d);
					ne = (v < 0) != (da < 0);
					nn = (u >= 0) != (da < 0);
					if (u == 0) nn = 0;
					o.eo = 32'(clamp32(ea + (ne ? -te : te)));
					o.no = 32'(clamp32(na + (nn ? -tn : tn)));
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// monitor: record what was accepted, predict on input, check on output
	always @(posedge clk) begin
		wind_res_t want;
		point_taken = start && !busy;
		scale_taken = cfg_valid && cfg_ready;
		if (scale_taken) begin
			scale_copy = cfg_data;
			scale_writes++;
		end
		if (point_taken) begin
			expected_winds.push_back(predict_wind('{0, '0, kind, east_wind, north_wind,
				east_perturbation, north_perturbation, east_adjoint_in,
				north_adjoint_in, direction_adjoint}, scale_copy));
			kind_count[kind]++;
		end
		if (done) begin
			if (expected_winds.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				want = expected_winds.pop_front();
				if (direction !== want.dir) begin
					$error("direction: expected %0d, got %0d", want.dir, direction);
					errors++;
				end
				if (direction_increment !== want.inc) begin
					$error("direction_increment: expected %0d, got %0d", want.inc,
						direction_increment);
					errors++;
				end
				if (east_adjoint_out !== want.eo) begin
					$error("east_adjoint_out: expected %0d, got %0d", want.eo,
						east_adjoint_out);
					errors++;
				end
				if (north_adjoint_out !== want.no) begin
					$error("north_adjoint_out: expected %0d, got %0d", want.no,
						north_adjoint_out);
					errors++;
				end
			end
		end
		idle_cycles = (point_taken || scale_taken || done) ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// driver: inputs move on the falling edge only
	always @(negedge clk) begin
		wind_item_t it;
		bit next_start;
		next_start = 0;
		quiet_cycles = (expected_winds.size() == 0 && !start) ? quiet_cycles + 1 : 0;
		if (arst_n) begin
			if (cfg_valid && scale_taken) cfg_valid = 1'b0;
			if (start && !point_taken) begin
				next_start = 1;  // item not taken yet, hold it
			end else if (!cfg_valid) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_points.size() > 0) begin
					it = pending_points[0];
					if (it.is_cfg) begin
						// scale writes only once the pipe has drained
						if (quiet_cycles >= DRAIN_WAIT) begin
							void'(pending_points.pop_front());
							cfg_data = it.scale;
							cfg_valid = 1'b1;
						end
					end else begin
						void'(pending_points.pop_front());
						kind = it.kind;
						east_wind = it.u;
						north_wind = it.v;
						east_perturbation = it.du;
						north_perturbation = it.dv;
						east_adjoint_in = it.ea;
						north_adjoint_in = it.na;
						direction_adjoint = it.da;
						next_start = 1;
						// mostly back to back, some short gaps, a few long ones
						case ($urandom_range(19))
							0: gap = $urandom_range(40, 10);
							1, 2, 3, 4, 5: gap = $urandom_range(3, 1);
							default: gap = 0;
						endcase
					end
				end
			end
		end
		start = next_start;
	end

	function automatic wind_item_t point(logic [1:0] k, int u, int v, int du, int dv,
			longint ea, longint na, longint da);
		return '{0, '0, k, u[15:0], v[15:0], du[15:0], dv[15:0], ea[31:0], na[31:0],
			da[31:0]};
	endfunction

	function automatic wind_item_t random_point();
		wind_item_t it;
		it = '{default: '0};
		it.kind = ($urandom_range(29) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
		case ($urandom_range(3))
			0: begin  // light winds, exercises near-calm division
				it.u = $signed(16'($urandom_range(16))) - 16'sd8;
				it.v = $signed(16'($urandom_range(16))) - 16'sd8;
			end
			1: begin  // one axis zero
				it.u = $urandom_range(1) ? 16'($urandom) : '0;
				it.v = (it.u == 0) ? 16'($urandom) : '0;
			end
			default: begin
				it.u = 16'($urandom);
				it.v = 16'($urandom);
			end
		endcase
		it.du = 16'($urandom);
		it.dv = 16'($urandom);
		it.ea = $urandom;
		it.na = $urandom;
		it.da = ($urandom_range(3) == 0) ? 32'($signed(16'($urandom))) : 32'($urandom);
		return it;
	endfunction

	task automatic queue_scale(logic [22:0] s);
		pending_points.push_back('{1, s, '0, '0, '0, '0, '0, '0, '0, '0});
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) pending_points.push_back(random_point());
	endtask

	initial begin
		// directed: calm, axes, extremes, saturation, unused kind
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, 0, 0, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_TL, 0, 0, 100, -100, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_ADJ, 0, 0, 0, 0, 12345, -54321,
			999999));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, 256, 0, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, -256, 0, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, 0, 256, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, 0, -256, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, -1, -1, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, -32768, -32768, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, 32767, -32768, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, -32768, 32767, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_TL, 1, 0, 32767, -32768, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_TL, 0, 1, -32768, 32767, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_TL, -32768, -32768, 32767, 32767,
			0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_ADJ, 1, 0, 0, 0, 64'sh7FFFFFFF,
			64'sh7FFFFFFF, 64'sh7FFFFFFF));
		pending_points.push_back(point(wdadj_pkg::KIND_ADJ, 0, -1, 0, 0, -64'sh80000000,
			-64'sh80000000, -64'sh80000000));
		pending_points.push_back(point(wdadj_pkg::KIND_ADJ, 0, 5, 0, 0, 0, 7, -65536));
		pending_points.push_back(point(wdadj_pkg::KIND_ADJ, 32767, 32767, 0, 0, -1, 1,
			65536));
		pending_points.push_back(point(KIND_UNUSED, 300, -400, 5, 6, 7, 8, 9));
		queue_random(60);
		queue_scale('0);
		queue_random(50);
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, -100, -100, 0, 0, 0, 0, 0));
		queue_scale(23'h7FFFFF);
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, -100, -100, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_DIR, 100, -1, 0, 0, 0, 0, 0));
		pending_points.push_back(point(wdadj_pkg::KIND_TL, 1, 0, 32767, 0, 0, 0, 0));
		queue_random(70);
		queue_scale(23'($urandom));
		queue_random(80);
		queue_scale(wdadj_pkg::DPR_RESET);
		queue_random(120);

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (pending_points.size() == 0 && !start && !cfg_valid
			&& expected_winds.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d direction, %0d increment, %0d adjoint, %0d unused-kind items",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		$display("with %0d scale writes including both extremes", scale_writes);
		if (errors == 0 && expected_winds.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
